>>> hw/rtl/sse_pkg.sv
// Package for the selection sort engine: sizes, record and transaction types.
package sse_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        payload;
    } t_rec;

    typedef struct packed {
        logic signed [31:0] key;
        logic [63:0]        payload;
        logic               last;
    } t_in;

    typedef struct packed {
        logic signed [31:0] sorted_key;
        logic [63:0]        sorted_payload;
        logic               end_of_set;
        logic               overflowed;
    } t_out;

    typedef struct packed {
        logic init;
        logic cmp;
    } t_min_ctl;

endpackage

>>> hw/rtl/sse_min_unit.sv
// Running-minimum unit: signed key compare, keeps first minimum record and its index.
module sse_min_unit
    import sse_pkg::*;
(
    input  logic             i_clk,
    input  t_min_ctl         i_ctl,
    input  t_rec             i_rec,
    input  logic [IDX_W-1:0] i_idx,
    output t_rec             o_best_rec,
    output logic [IDX_W-1:0] o_best_idx
);

    t_rec             r_best_rec;
    logic [IDX_W-1:0] r_best_idx;
    logic             less;

    assign less = i_rec.key < r_best_rec.key;

    always_ff @(posedge i_clk) begin
        if (i_ctl.init || (i_ctl.cmp && less)) begin
            r_best_rec <= i_rec;
            r_best_idx <= i_idx;
        end
    end

    assign o_best_rec = r_best_rec;
    assign o_best_idx = r_best_idx;

endmodule

>>> hw/rtl/selection_sort_engine_unit.sv
// Top level of the selection sort engine: record store, sort sequencer, output stage.
//
// Records are loaded one per cycle into a 32-entry store until a transaction
// with last set arrives; records beyond the store size are dropped and flag
// overflowed on every result of that set. The set is then sorted ascending by
// signed key with selection sort on one shared compare unit, one store read per
// cycle; for each position the rest of the set is scanned for its minimum, which
// is then swapped in by two store writes. Results leave one at a time, each
// read only after the previous one is taken, the last one with end_of_set; the
// input is not ready from the last record until the final result is taken.
module selection_sort_engine_unit
    import sse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_PREP      = 4'd1;
    localparam logic [3:0] S_FIRST     = 4'd2;
    localparam logic [3:0] S_SCAN      = 4'd3;
    localparam logic [3:0] S_SWAP1     = 4'd4;
    localparam logic [3:0] S_SWAP2     = 4'd5;
    localparam logic [3:0] S_EMIT_RD   = 4'd6;
    localparam logic [3:0] S_EMIT_LD   = 4'd7;
    localparam logic [3:0] S_EMIT_WAIT = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_ovf, n_ovf;
    logic [IDX_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_idx, n_idx;
    t_rec             r_pos_rec, n_pos_rec;
    t_out             r_out, n_out;
    logic             r_out_valid, n_out_valid;

    t_rec             mem [DEPTH];
    t_rec             r_rd_data;
    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    t_rec             wdata;

    t_min_ctl         min_ctl;
    t_rec             best_rec;
    logic [IDX_W-1:0] best_idx;

    logic [CNT_W-1:0] cnt_m1;
    logic [IDX_W-1:0] last_idx;
    logic [IDX_W-1:0] pos_p1;
    logic             in_acc;

    assign cnt_m1   = r_count - CNT_W'(1);
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign pos_p1   = r_pos + IDX_W'(1);
    assign in_acc   = i_in_valid && o_in_ready;

    sse_min_unit u_min (
        .i_clk      (i_clk),
        .i_ctl      (min_ctl),
        .i_rec      (r_rd_data),
        .i_idx      ((r_state == S_FIRST) ? r_pos : r_idx),
        .o_best_rec (best_rec),
        .o_best_idx (best_idx)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_pos       = r_pos;
        n_idx       = r_idx;
        n_pos_rec   = r_pos_rec;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        we          = 1'b0;
        waddr       = r_pos;
        wdata       = r_pos_rec;
        raddr       = r_pos;
        min_ctl     = '0;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    if (r_count < CNT_W'(DEPTH)) begin
                        we      = 1'b1;
                        waddr   = r_count[IDX_W-1:0];
                        wdata   = '{key: i_in_data.key, payload: i_in_data.payload};
                        n_count = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last) begin
                        n_pos = '0;
                        n_idx = '0;
                        n_state = (n_count == CNT_W'(1)) ? S_EMIT_RD : S_PREP;
                    end
                end
            end
            S_PREP: begin
                raddr   = r_pos;
                n_state = S_FIRST;
            end
            S_FIRST: begin
                min_ctl.init = 1'b1;
                n_pos_rec    = r_rd_data;
                raddr        = pos_p1;
                n_idx        = pos_p1;
                n_state      = S_SCAN;
            end
            S_SCAN: begin
                min_ctl.cmp = 1'b1;
                raddr       = r_idx + IDX_W'(1);
                n_idx       = r_idx + IDX_W'(1);
                if (r_idx == last_idx) begin
                    n_state = S_SWAP1;
                end
            end
            S_SWAP1: begin
                we      = 1'b1;
                waddr   = r_pos;
                wdata   = best_rec;
                n_state = S_SWAP2;
            end
            S_SWAP2: begin
                we    = 1'b1;
                waddr = best_idx;
                wdata = r_pos_rec;
                n_pos = pos_p1;
                if (pos_p1 == last_idx) begin
                    n_idx   = '0;
                    n_state = S_EMIT_RD;
                end else begin
                    n_state = S_PREP;
                end
            end
            S_EMIT_RD: begin
                raddr   = r_idx;
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_out.sorted_key     = r_rd_data.key;
                n_out.sorted_payload = r_rd_data.payload;
                n_out.end_of_set     = (r_idx == last_idx);
                n_out.overflowed     = r_ovf;
                n_out_valid          = 1'b1;
                n_state              = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out.end_of_set) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos_rec <= n_pos_rec;
        r_out     <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rd_data <= mem[raddr];
    end

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("record count beyond store size");

    a_scan_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx > r_pos))
        else $error("scan index not past sort position");

    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWAP1) |-> (best_idx >= r_pos && best_idx <= last_idx))
        else $error("minimum index outside unsorted range");

    a_set_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_out_data.end_of_set)
        |=> (r_count == '0 && !r_ovf && o_in_ready))
        else $error("set state not cleared after final result");

endmodule

>>> tb/tb_top.sv
// Testbench for selection_sort_engine_unit: random record sets, sort prediction, ordered checks.
`timescale 1ns / 100ps

module tb_top
    import sse_pkg::*;
();

    localparam int STALL_LIMIT = 5000;

    class sort_predictor;
        logic signed [31:0] key_mem [DEPTH];
        logic [63:0]        pay_mem [DEPTH];
        int unsigned        rec_cnt;
        bit                 dropped;
        t_out               ordered_q [$];
        int unsigned        errors;

        function new();
            rec_cnt = 0;
            dropped = 0;
            errors  = 0;
        endfunction

        function void report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endfunction

        function void sort_held();
            int unsigned        p;
            int unsigned        s;
            int unsigned        m;
            logic signed [31:0] tk;
            logic [63:0]        tp;
            for (p = 0; p + 1 < rec_cnt; p++) begin
                m = p;
                for (s = p + 1; s < rec_cnt; s++) begin
                    if (key_mem[s] < key_mem[m]) m = s;
                end
                if (m != p) begin
                    tk = key_mem[p];
                    tp = pay_mem[p];
                    key_mem[p] = key_mem[m];
                    pay_mem[p] = pay_mem[m];
                    key_mem[m] = tk;
                    pay_mem[m] = tp;
                end
            end
        endfunction

        function void note_record(t_in rec);
            t_out        e;
            int unsigned r;
            if (rec_cnt < DEPTH) begin
                key_mem[rec_cnt] = rec.key;
                pay_mem[rec_cnt] = rec.payload;
                rec_cnt++;
            end else begin
                dropped = 1;
            end
            if (rec.last) begin
                sort_held();
                for (r = 0; r < rec_cnt; r++) begin
                    e.sorted_key     = key_mem[r];
                    e.sorted_payload = pay_mem[r];
                    e.end_of_set     = (r + 1 == rec_cnt);
                    e.overflowed     = dropped;
                    ordered_q.push_back(e);
                end
                rec_cnt = 0;
                dropped = 0;
            end
        endfunction

        function void check_sorted(t_out got);
            t_out exp;
            if (ordered_q.size() == 0) begin
                report($sformatf("unexpected result key=%0d", got.sorted_key));
                return;
            end
            exp = ordered_q.pop_front();
            if (got.sorted_key !== exp.sorted_key)
                report($sformatf("sorted_key %0d, want %0d", got.sorted_key, exp.sorted_key));
            if (got.sorted_payload !== exp.sorted_payload)
                report($sformatf("sorted_payload %h, want %h",
                                 got.sorted_payload, exp.sorted_payload));
            if (got.end_of_set !== exp.end_of_set)
                report($sformatf("end_of_set %b, want %b", got.end_of_set, exp.end_of_set));
            if (got.overflowed !== exp.overflowed)
                report($sformatf("overflowed %b, want %b", got.overflowed, exp.overflowed));
        endfunction

        function int pending();
            return ordered_q.size();
        endfunction
    endclass

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    sort_predictor sb;
    int            sent     = 0;
    int            cyc      = 0;
    int            idle_cnt = 0;
    int            dir_keys [$];

    selection_sort_engine_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic send_rec(input logic signed [31:0] k, input logic [63:0] p, input logic l);
        t_in item;
        item.key     = k;
        item.payload = p;
        item.last    = l;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_record(item);
        sent++;
        // no gaps for a stretch of transactions
        if (!(sent >= 60 && sent < 100) && $urandom_range(0, 99) < 16) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [31:0] pick_key(int mode);
        logic signed [31:0] k;
        case (mode)
            0: k = $urandom;
            1: k = $signed($urandom_range(0, 7)) - 4;
            default: begin
                case ($urandom_range(0, 3))
                    0: k = 32'sh80000000;
                    1: k = 32'sh7fffffff;
                    2: k = 0;
                    default: k = -1;
                endcase
            end
        endcase
        return k;
    endfunction

    task automatic send_set(int n, int mode);
        int i;
        for (i = 0; i < n; i++)
            send_rec(pick_key(mode), {$urandom, $urandom}, i == n - 1);
    endtask

    task automatic send_dir();
        int i;
        for (i = 0; i < dir_keys.size(); i++)
            send_rec(dir_keys[i], {$urandom, 16'h0000, i[15:0]}, i == dir_keys.size() - 1);
    endtask

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (i_rst_n && o_out_valid && i_out_ready) sb.check_sorted(o_out_data);
        i_out_ready <= (cyc % 4000 < 1500) || ($urandom_range(0, 99) >= 16);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cnt <= 0;
        end else if (idle_cnt >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cnt <= idle_cnt + 1;
        end
    end

    initial begin
        int n;
        int rand_start;
        int big_q [$];
        sb = new();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // single-record sets at the key and payload extremes, then a set of extreme keys
        send_rec(32'sh80000000, '1, 1'b1);
        send_rec(32'sh7fffffff, '0, 1'b1);
        dir_keys = '{0, -1, 32'h7fffffff, 32'h80000000, 1};
        send_dir();
        // repeated keys: placement follows the swap order, not arrival
        dir_keys = '{3, 1, 3, 1, 3, 2};
        send_dir();
        dir_keys = '{32'h55555555, 32'h55555555, 32'h55555555, 32'h55555555};
        send_dir();
        dir_keys = '{-7, 9};
        send_dir();
        dir_keys = '{5, 0, -5};
        send_dir();

        // one exactly full set and one overflowing set, dropped last included
        big_q.push_back(DEPTH);
        big_q.push_back(DEPTH + $urandom_range(1, 3));
        rand_start = sent;
        while (sent - rand_start < 90) begin
            if (big_q.size() > 0 && $urandom_range(0, 5) == 0) n = big_q.pop_front();
            else n = $urandom_range(1, 8);
            send_set(n, $urandom_range(0, 2));
        end
        while (big_q.size() > 0) send_set(big_q.pop_front(), $urandom_range(0, 2));
        i_in_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
